// ===== rtl/core/mgs_pkg.sv =====
// ----------------------------------------------------------------------------
// mgs_pkg
// Shared types, constants and helpers of the multivector gradient stencil.
// ----------------------------------------------------------------------------
package mgs_pkg;

  localparam int MAX_CELLS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NCOMP         = 8;
  localparam int NDIM          = 3;
  localparam int NREAD         = 6;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_INDEX_W   = 3;

  // component (and result) slots within a cell
  localparam int COMP_SCALAR = 0;
  localparam int COMP_VEC    = 1;
  localparam int COMP_BIV    = 4;
  localparam int COMP_PSEUDO = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIMS    = 3'd0,
    REG_CELLS_X = 3'd1,
    REG_CELLS_Y = 3'd2,
    REG_CELLS_Z = 3'd3,
    REG_INV_X   = 3'd4,
    REG_INV_Y   = 3'd5,
    REG_INV_Z   = 3'd6
  } cfg_reg_e;

  typedef logic [NCOMP-1:0][31:0] cell_t;
  typedef logic [NDIM-1:0][31:0]  inv_t;

  // one stencil job: sign and magnitude of each difference, per result and axis
  typedef struct packed {
    logic                              last;
    logic [NCOMP-1:0][NDIM-1:0]        neg;
    logic [NCOMP-1:0][NDIM-1:0][31:0]  mag;
  } diff_t;

  function automatic int axis_next(int d);
    return (d == NDIM - 1) ? 0 : d + 1;
  endfunction

endpackage

// ===== rtl/core/mgs_if.sv =====
// ----------------------------------------------------------------------------
// mgs_if
// Valid/ready channels for cells in and gradients out.
// ----------------------------------------------------------------------------
interface mgs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] scalar_part;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] biv_x;
  logic signed [31:0] biv_y;
  logic signed [31:0] biv_z;
  logic signed [31:0] pseudo_part;

  modport source (output valid, scalar_part, vec_x, vec_y, vec_z,
                  biv_x, biv_y, biv_z, pseudo_part, input ready);
  modport sink   (input valid, scalar_part, vec_x, vec_y, vec_z,
                  biv_x, biv_y, biv_z, pseudo_part, output ready);
endinterface

interface mgs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] grad_scalar;
  logic signed [31:0] grad_vec_x;
  logic signed [31:0] grad_vec_y;
  logic signed [31:0] grad_vec_z;
  logic signed [31:0] grad_biv_x;
  logic signed [31:0] grad_biv_y;
  logic signed [31:0] grad_biv_z;
  logic signed [31:0] grad_pseudo;
  logic               last_cell;

  modport source (output valid, grad_scalar, grad_vec_x, grad_vec_y, grad_vec_z,
                  grad_biv_x, grad_biv_y, grad_biv_z, grad_pseudo, last_cell,
                  input ready);
  modport sink   (input valid, grad_scalar, grad_vec_x, grad_vec_y, grad_vec_z,
                  grad_biv_x, grad_biv_y, grad_biv_z, grad_pseudo, last_cell,
                  output ready);
endinterface

// ===== rtl/core/mgs_front.sv =====
// ----------------------------------------------------------------------------
// mgs_front
// Raster position tracking, two-plane store and difference forming.
// ----------------------------------------------------------------------------
module mgs_front #(
  parameter int MAX_CELLS = mgs_pkg::MAX_CELLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             geom_clr,
  input  logic [1:0]                       dims,
  input  logic [$clog2(MAX_CELLS+1)-1:0]   cells_x,
  input  logic [$clog2(MAX_CELLS+1)-1:0]   cells_y,
  input  logic [$clog2(MAX_CELLS+1)-1:0]   cells_z,
  mgs_in_if.sink                           cell_in,
  input  logic                             q_full,
  output logic                             q_push,
  output mgs_pkg::diff_t                   q_data
);
  import mgs_pkg::*;

  localparam int EXT   = MAX_CELLS + 2;
  localparam int PW    = $clog2(EXT);
  localparam int DEPTH = 2 * EXT * EXT;
  localparam int AW    = $clog2(DEPTH);

  logic [PW-1:0]  pos_x, pos_y, pos_z;
  logic [PW-1:0]  pos_x_next, pos_y_next, pos_z_next;
  logic [PW-1:0]  cx_p, cy_p, cz_p;
  logic [PW:0]    lim_x, lim_y, lim_z;
  logic           front_adv, acc, emit, last;
  logic           zp, zq;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr [NREAD];
  cell_t          inc;
  cell_t          rd_data [NREAD];
  cell_t          mem0 [DEPTH];
  cell_t          mem1 [DEPTH];
  cell_t          mem2 [DEPTH];
  logic           f1_valid, f1_emit, f1_last;
  logic [1:0]     f1_nd;
  cell_t          f1_inc;
  cell_t          c [7];

  function automatic logic [AW-1:0] addr_of(logic par, logic [PW-1:0] y,
                                            logic [PW-1:0] x);
    return AW'(par) * AW'(EXT * EXT) + AW'(y) * AW'(EXT) + AW'(x);
  endfunction

  function automatic logic [32:0] diff_of(logic [31:0] hi, logic [31:0] lo);
    logic signed [32:0] dv;
    dv = $signed({hi[31], hi}) - $signed({lo[31], lo});
    return dv[32] ? {1'b1, 32'(-dv)} : {1'b0, dv[31:0]};
  endfunction

  assign inc = {cell_in.pseudo_part, cell_in.biv_z, cell_in.biv_y, cell_in.biv_x,
                cell_in.vec_z, cell_in.vec_y, cell_in.vec_x, cell_in.scalar_part};

  assign front_adv     = !(f1_valid && f1_emit && q_full);
  assign cell_in.ready = front_adv;
  assign acc           = cell_in.valid && front_adv;
  assign q_push        = f1_valid && f1_emit && !q_full;

  assign cx_p = PW'(cells_x);
  assign cy_p = PW'(cells_y);
  assign cz_p = PW'(cells_z);
  assign zp   = pos_z[0];
  assign zq   = ~pos_z[0];

  // stream extents, ghosts only on active axes
  always_comb begin
    lim_x = {1'b0, cx_p} + (PW+1)'(2);
    lim_y = (dims >= 2'd2) ? {1'b0, cy_p} + (PW+1)'(2) : {1'b0, cy_p};
    lim_z = (dims == 2'd3) ? {1'b0, cz_p} + (PW+1)'(2) : {1'b0, cz_p};
  end

  always_comb begin
    pos_x_next = pos_x + PW'(1);
    pos_y_next = pos_y;
    pos_z_next = pos_z;
    if ({1'b0, pos_x} + (PW+1)'(1) >= lim_x) begin
      pos_x_next = '0;
      pos_y_next = pos_y + PW'(1);
      if ({1'b0, pos_y} + (PW+1)'(1) >= lim_y) begin
        pos_y_next = '0;
        pos_z_next = pos_z + PW'(1);
        if ({1'b0, pos_z} + (PW+1)'(1) >= lim_z) begin
          pos_z_next = '0;
        end
      end
    end
  end

  // the arriving cell is the forward neighbour along the last active axis
  always_comb begin
    wr_addr = addr_of(zp, pos_y, pos_x);
    for (int k = 0; k < NREAD; k++) begin
      rd_addr[k] = '0;
    end
    priority if (dims == 2'd1) begin
      emit       = pos_x >= PW'(2);
      last       = pos_x == cx_p + PW'(1) && pos_y == cy_p - PW'(1)
                   && pos_z == cz_p - PW'(1);
      rd_addr[0] = addr_of(zp, pos_y, pos_x - PW'(1));
      rd_addr[1] = addr_of(zp, pos_y, pos_x - PW'(2));
    end else if (dims == 2'd2) begin
      emit       = pos_x >= PW'(1) && pos_x <= cx_p && pos_y >= PW'(2);
      last       = pos_x == cx_p && pos_y == cy_p + PW'(1) && pos_z == cz_p - PW'(1);
      rd_addr[0] = addr_of(zp, pos_y - PW'(1), pos_x);
      rd_addr[1] = addr_of(zp, pos_y - PW'(1), pos_x - PW'(1));
      rd_addr[2] = addr_of(zp, pos_y - PW'(1), pos_x + PW'(1));
      rd_addr[3] = addr_of(zp, pos_y - PW'(2), pos_x);
    end else begin
      emit       = pos_x >= PW'(1) && pos_x <= cx_p && pos_y >= PW'(1)
                   && pos_y <= cy_p && pos_z >= PW'(2);
      last       = pos_x == cx_p && pos_y == cy_p && pos_z == cz_p + PW'(1);
      rd_addr[0] = addr_of(zq, pos_y, pos_x);
      rd_addr[1] = addr_of(zq, pos_y, pos_x - PW'(1));
      rd_addr[2] = addr_of(zq, pos_y, pos_x + PW'(1));
      rd_addr[3] = addr_of(zq, pos_y - PW'(1), pos_x);
      rd_addr[4] = addr_of(zq, pos_y + PW'(1), pos_x);
      // same entry the arriving beat overwrites: read returns the old plane
      rd_addr[5] = addr_of(zp, pos_y, pos_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geom_clr) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (acc) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

  // three identical copies give six read ports
  always_ff @(posedge clk) begin
    if (acc) begin
      mem0[wr_addr] <= inc;
      mem1[wr_addr] <= inc;
      mem2[wr_addr] <= inc;
      rd_data[0]    <= mem0[rd_addr[0]];
      rd_data[1]    <= mem0[rd_addr[1]];
      rd_data[2]    <= mem1[rd_addr[2]];
      rd_data[3]    <= mem1[rd_addr[3]];
      rd_data[4]    <= mem2[rd_addr[4]];
      rd_data[5]    <= mem2[rd_addr[5]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (front_adv) begin
      f1_valid <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1_emit <= emit;
      f1_last <= last;
      f1_nd   <= dims;
      f1_inc  <= inc;
    end
  end

  always_comb begin
    for (int k = 0; k < NREAD; k++) begin
      c[k] = rd_data[k];
    end
    c[6] = f1_inc;
    c[{f1_nd, 1'b0}] = f1_inc;
  end

  // vector and pseudoscalar take backward differences, scalar and bivector forward
  // ones, reversed in the curl terms; curl signs are folded into the operand order
  always_comb begin
    cell_t ci, cm, cp;
    int    e, f;
    q_data      = '0;
    q_data.last = f1_last;
    ci          = c[0];
    for (int d = 0; d < NDIM; d++) begin
      e  = axis_next(d);
      f  = axis_next(axis_next(d));
      cm = c[1 + 2 * d];
      cp = c[2 + 2 * d];
      if (d < int'(f1_nd)) begin
        {q_data.neg[COMP_SCALAR][d], q_data.mag[COMP_SCALAR][d]} =
          diff_of(ci[COMP_VEC + d], cm[COMP_VEC + d]);
        {q_data.neg[COMP_PSEUDO][d], q_data.mag[COMP_PSEUDO][d]} =
          diff_of(cp[COMP_BIV + d], ci[COMP_BIV + d]);
        {q_data.neg[COMP_VEC + d][d], q_data.mag[COMP_VEC + d][d]} =
          diff_of(cp[COMP_SCALAR], ci[COMP_SCALAR]);
        {q_data.neg[COMP_BIV + d][d], q_data.mag[COMP_BIV + d][d]} =
          diff_of(ci[COMP_PSEUDO], cm[COMP_PSEUDO]);
        {q_data.neg[COMP_VEC + e][d], q_data.mag[COMP_VEC + e][d]} =
          diff_of(ci[COMP_BIV + f], cm[COMP_BIV + f]);
        {q_data.neg[COMP_VEC + f][d], q_data.mag[COMP_VEC + f][d]} =
          diff_of(cm[COMP_BIV + e], ci[COMP_BIV + e]);
        {q_data.neg[COMP_BIV + f][d], q_data.mag[COMP_BIV + f][d]} =
          diff_of(cp[COMP_VEC + e], ci[COMP_VEC + e]);
        {q_data.neg[COMP_BIV + e][d], q_data.mag[COMP_BIV + e][d]} =
          diff_of(ci[COMP_VEC + f], cp[COMP_VEC + f]);
      end
    end
  end

  a_acc_loads_f1: assert property (@(posedge clk) disable iff (rst)
    acc |=> f1_valid)
    else $error("accepted beat did not reach the difference stage");

endmodule

// ===== rtl/core/mgs_queue.sv =====
// ----------------------------------------------------------------------------
// mgs_queue
// Short FIFO of stencil jobs between the front and the multiply back end.
// ----------------------------------------------------------------------------
module mgs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mgs_pkg::diff_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output mgs_pkg::diff_t rd_data
);
  import mgs_pkg::*;

  // depth is a power of two, pointers wrap naturally
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  diff_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> rd_valid)
    else $error("pop from empty queue");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (push == pop) |=> $stable(count))
    else $error("queue count moved without net traffic");

endmodule

// ===== rtl/core/mgs_back.sv =====
// ----------------------------------------------------------------------------
// mgs_back
// Scaling by reciprocal widths, rounding, summing and saturation.
// ----------------------------------------------------------------------------
module mgs_back #(
  parameter int FRAC_BITS = mgs_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mgs_pkg::diff_t q_data,
  output logic           q_pop,
  input  mgs_pkg::inv_t  inv,
  mgs_out_if.source      grad_out
);
  import mgs_pkg::*;

  localparam int RW = 65 - FRAC_BITS;
  localparam int TW = RW + 1;
  localparam int SW = TW + 2;

  logic                       adv;
  logic                       b1_valid, b1_last;
  logic [NCOMP-1:0][NDIM-1:0] b1_neg;
  logic [63:0]                b1_prod [NCOMP][NDIM];
  logic                       b2_valid, b2_last;
  logic signed [TW-1:0]       b2_term [NCOMP][NDIM];
  logic signed [TW-1:0]       term_c  [NCOMP][NDIM];
  logic                       o_valid, o_last;
  logic [31:0]                o_res [NCOMP];
  logic [31:0]                res_c [NCOMP];

  assign adv   = !o_valid || grad_out.ready;
  assign q_pop = adv && q_valid;

  // round half away from zero on the magnitude, then restore the sign
  always_comb begin
    logic [64:0]          rnd;
    logic [RW-1:0]        r;
    logic signed [TW-1:0] t;
    for (int o = 0; o < NCOMP; o++) begin
      for (int d = 0; d < NDIM; d++) begin
        rnd = {1'b0, b1_prod[o][d]} + (65'(1) << (FRAC_BITS - 1));
        r   = RW'(rnd >> FRAC_BITS);
        t   = $signed({1'b0, r});
        term_c[o][d] = b1_neg[o][d] ? -t : t;
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] s;
    for (int o = 0; o < NCOMP; o++) begin
      s = SW'(b2_term[o][0]) + SW'(b2_term[o][1]) + SW'(b2_term[o][2]);
      if (s[SW-1:31] == '0 || s[SW-1:31] == '1) begin
        res_c[o] = s[31:0];
      end else begin
        res_c[o] = s[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      b1_valid <= q_valid;
      b2_valid <= b1_valid;
      o_valid  <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_last <= q_data.last;
      b1_neg  <= q_data.neg;
      for (int o = 0; o < NCOMP; o++) begin
        for (int d = 0; d < NDIM; d++) begin
          b1_prod[o][d] <= 64'(q_data.mag[o][d]) * 64'(inv[d]);
          b2_term[o][d] <= term_c[o][d];
        end
        o_res[o] <= res_c[o];
      end
      b2_last <= b1_last;
      o_last  <= b2_last;
    end
  end

  assign grad_out.valid       = o_valid;
  assign grad_out.grad_scalar = o_res[COMP_SCALAR];
  assign grad_out.grad_vec_x  = o_res[COMP_VEC];
  assign grad_out.grad_vec_y  = o_res[COMP_VEC + 1];
  assign grad_out.grad_vec_z  = o_res[COMP_VEC + 2];
  assign grad_out.grad_biv_x  = o_res[COMP_BIV];
  assign grad_out.grad_biv_y  = o_res[COMP_BIV + 1];
  assign grad_out.grad_biv_z  = o_res[COMP_BIV + 2];
  assign grad_out.grad_pseudo = o_res[COMP_PSEUDO];
  assign grad_out.last_cell   = o_last;

  a_stall_holds_job: assert property (@(posedge clk) disable iff (rst)
    (b1_valid && !adv) |=> b1_valid)
    else $error("job lost in the multiply stage while stalled");

endmodule

// ===== rtl/core/multivector_gradient_stencil_unit.sv =====
// ----------------------------------------------------------------------------
// multivector_gradient_stencil_unit
// Staggered difference gradient of a streamed 8-component multivector grid.
// ----------------------------------------------------------------------------
// Cells enter on cell_in in raster order (x fastest), ghosts included on
// every active axis. A gradient beat leaves on grad_out for each interior
// cell, once its forward neighbour along the last active axis has arrived;
// last_cell marks the final one of the grid. Configuration is written on
// cfg_wr_en/cfg_index/cfg_data while the block is idle; a geometry write
// restarts the raster at the origin.
// One cell per cycle is sustained while cell_in holds ready. On the beat
// that completes a stencil, the plane store read and the difference stage
// are registered on the accepting edge; the differences then enter the job
// queue and pass through the multiply, round and sum/saturate stages in turn.
// The plane store has three copies to give six ports for the neighbour
// reads. A four-entry job queue sits between front and back; when grad_out
// stalls the back end holds, the queue fills, and only then cell_in drops
// ready. Reset clears positions and restores register defaults; store
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module multivector_gradient_stencil_unit #(
  parameter int MAX_CELLS = mgs_pkg::MAX_CELLS_DEF,
  parameter int FRAC_BITS = mgs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [mgs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  mgs_in_if.sink                          cell_in,
  mgs_out_if.source                       grad_out
);
  import mgs_pkg::*;

  localparam int CW          = $clog2(MAX_CELLS + 1);
  localparam int RESET_CELLS = (MAX_CELLS < 64) ? MAX_CELLS : 64;

  logic [1:0]    dims;
  logic [CW-1:0] cells_x, cells_y, cells_z;
  inv_t          inv;
  logic          geom_clr;
  logic          q_push, q_full, q_valid, q_pop;
  diff_t         q_wr, q_rd;

  function automatic logic [CW-1:0] clamp_cells(logic [6:0] v);
    if (v == 7'd0) begin
      return CW'(1);
    end
    if (int'(v) > MAX_CELLS) begin
      return CW'(MAX_CELLS);
    end
    return CW'(v);
  endfunction

  assign geom_clr = cfg_wr_en && (cfg_index == REG_DIMS || cfg_index == REG_CELLS_X
                                  || cfg_index == REG_CELLS_Y
                                  || cfg_index == REG_CELLS_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      dims    <= 2'd3;
      cells_x <= CW'(RESET_CELLS);
      cells_y <= CW'(RESET_CELLS);
      cells_z <= CW'(RESET_CELLS);
      inv     <= {NDIM{32'h0001_0000}};
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DIMS:    dims    <= (cfg_data[1:0] == 2'd0) ? 2'd1 : cfg_data[1:0];
        REG_CELLS_X: cells_x <= clamp_cells(cfg_data[6:0]);
        REG_CELLS_Y: cells_y <= clamp_cells(cfg_data[6:0]);
        REG_CELLS_Z: cells_z <= clamp_cells(cfg_data[6:0]);
        REG_INV_X:   inv[0]  <= cfg_data;
        REG_INV_Y:   inv[1]  <= cfg_data;
        REG_INV_Z:   inv[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  mgs_front #(.MAX_CELLS(MAX_CELLS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .geom_clr (geom_clr),
    .dims     (dims),
    .cells_x  (cells_x),
    .cells_y  (cells_y),
    .cells_z  (cells_z),
    .cell_in  (cell_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr)
  );

  mgs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd)
  );

  mgs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_rd),
    .q_pop    (q_pop),
    .inv      (inv),
    .grad_out (grad_out)
  );

endmodule

// ===== test/multivector_gradient_stencil_unit_test.sv =====
// ----------------------------------------------------------------------------
// multivector_gradient_stencil_unit_test
// Self-checking bench: cells are streamed over a range of grid geometries
// and reciprocal widths. Every gradient beat is compared with a local
// prediction of the staggered stencil.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multivector_gradient_stencil_unit_test;
  import mgs_pkg::*;

  localparam int          EXT        = MAX_CELLS_DEF + 2;
  localparam int          RAND_ITEMS = 1000;
  localparam int          TIMEOUT    = 400000;
  localparam int          DRAIN_WAIT = 12;
  localparam logic [31:0] QMIN       = 32'h8000_0000;
  localparam logic [31:0] QMAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] ONE        = 32'h0001_0000;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic  last;
    cell_t g;
  } grad_t;

  typedef struct packed {
    cell_t c;
    logic  fixed;
    grad_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  mgs_in_if  cin ();
  mgs_out_if gout ();

  multivector_gradient_stencil_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cell_in  (cin),
    .grad_out (gout)
  );

  always #5 clk = ~clk;

  // predictor state
  cell_t       plane_mem [2][EXT][EXT];
  int          geo_dims, geo_x, geo_y, geo_z;
  logic [31:0] inv_w [3];
  int          px, py, pz;

  grad_t grad_expect [$];
  int    errors = 0;
  bit    calm   = 1'b0;
  int    cycles = 0;

  string comp_name [8] = '{"grad_scalar", "grad_vec_x", "grad_vec_y", "grad_vec_z",
                           "grad_biv_x", "grad_biv_y", "grad_biv_z", "grad_pseudo"};

  // grids of three cells along x: extremes, sign swap, zeros, then odd values
  dir_row_t dir_rows [12] = '{
    '{{8{QMIN}}, 1'b0, '0},
    '{{8{QMAX}}, 1'b0, '0},
    '{{8{QMIN}}, 1'b1, {1'b1, QMIN, QMIN, QMAX, QMAX, QMIN, QMAX, QMIN, QMAX}},
    '{{8{QMAX}}, 1'b0, '0},
    '{{8{QMIN}}, 1'b0, '0},
    '{{8{QMAX}}, 1'b1, {1'b1, QMAX, QMAX, QMIN, QMIN, QMAX, QMIN, QMAX, QMIN}},
    '{'0, 1'b0, '0},
    '{'0, 1'b0, '0},
    '{'0, 1'b1, {1'b1, 256'b0}},
    '{{8{32'h0001_8000}}, 1'b0, '0},
    '{{8{32'hFFFF_FFFF}}, 1'b0, '0},
    '{{ONE, 32'h0000_0001, QMAX, 32'hFFFE_8000, QMIN, ONE, 32'h0000_7FFF, 32'h1234_5678},
      1'b0, '0}
  };

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 30);
  endfunction

  function automatic longint diff_term(logic [31:0] hi, logic [31:0] lo, logic [31:0] inv);
    longint          d;
    longint unsigned m, iv, p, r;
    d  = longint'($signed(hi)) - longint'($signed(lo));
    m  = (d < 0) ? -d : d;
    iv = inv;
    p  = m * iv;
    r  = (p + 64'd32768) >> 16;
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [31:0] sat_q(longint v);
    if (v > 64'sd2147483647) return QMAX;
    if (v < -64'sd2147483648) return QMIN;
    return v[31:0];
  endfunction

  function automatic int clamp_cells(logic [31:0] v);
    int n;
    n = v[6:0];
    if (n == 0) return 1;
    if (n > MAX_CELLS_DEF) return MAX_CELLS_DEF;
    return n;
  endfunction

  // advances the raster by one accepted cell; returns 1 when a gradient is due
  function automatic bit stencil_step(cell_t inc, output grad_t r);
    int     ex, ey, ez, cx, cy, cz, e, f;
    bit     emit;
    cell_t  c [7];
    longint gs, gp;
    longint gv [3];
    longint gb [3];
    ex = geo_x + 2;
    ey = (geo_dims >= 2) ? geo_y + 2 : geo_y;
    ez = (geo_dims >= 3) ? geo_z + 2 : geo_z;
    cx = px; cy = py; cz = pz;
    r  = '0;
    if (geo_dims == 1) begin
      emit = px >= 2;
      cx   = px - 1;
    end else if (geo_dims == 2) begin
      emit = px >= 1 && px <= geo_x && py >= 2;
      cy   = py - 1;
    end else begin
      emit = px >= 1 && px <= geo_x && py >= 1 && py <= geo_y && pz >= 2;
      cz   = pz - 1;
    end
    if (emit) begin
      gs = 0; gp = 0;
      gv = '{0, 0, 0};
      gb = '{0, 0, 0};
      c[0] = plane_mem[cz & 1][cy][cx];
      c[1] = plane_mem[cz & 1][cy][cx - 1];
      c[2] = plane_mem[cz & 1][cy][cx + 1];
      if (geo_dims >= 2) begin
        c[3] = plane_mem[cz & 1][cy - 1][cx];
        c[4] = plane_mem[cz & 1][cy + 1][cx];
      end
      if (geo_dims >= 3) begin
        c[5] = plane_mem[(cz - 1) & 1][cy][cx];
        c[6] = plane_mem[(cz + 1) & 1][cy][cx];
      end
      // the forward neighbour on the last active axis is the arriving cell
      c[2 * geo_dims] = inc;
      for (int d = 0; d < geo_dims; d++) begin
        e = (d + 1) % 3;
        f = (d + 2) % 3;
        gs    += diff_term(c[0][1 + d], c[1 + 2 * d][1 + d], inv_w[d]);
        gp    += diff_term(c[2 + 2 * d][4 + d], c[0][4 + d], inv_w[d]);
        gv[d] += diff_term(c[2 + 2 * d][0], c[0][0], inv_w[d]);
        gb[d] += diff_term(c[0][7], c[1 + 2 * d][7], inv_w[d]);
        gv[e] += diff_term(c[0][4 + f], c[1 + 2 * d][4 + f], inv_w[d]);
        gv[f] -= diff_term(c[0][4 + e], c[1 + 2 * d][4 + e], inv_w[d]);
        gb[f] += diff_term(c[2 + 2 * d][1 + e], c[0][1 + e], inv_w[d]);
        gb[e] -= diff_term(c[2 + 2 * d][1 + f], c[0][1 + f], inv_w[d]);
      end
      r.g[0] = sat_q(gs);
      for (int k = 0; k < 3; k++) begin
        r.g[1 + k] = sat_q(gv[k]);
        r.g[4 + k] = sat_q(gb[k]);
      end
      r.g[7] = sat_q(gp);
      r.last = cx == geo_x && cy == ((geo_dims >= 2) ? geo_y : geo_y - 1)
               && cz == ((geo_dims >= 3) ? geo_z : geo_z - 1);
    end
    plane_mem[pz & 1][py][px] = inc;
    px++;
    if (px >= ex) begin
      px = 0;
      py++;
      if (py >= ey) begin
        py = 0;
        pz++;
        if (pz >= ez) pz = 0;
      end
    end
    return emit;
  endfunction

  // called at a falling edge; returns at the falling edge after the write
  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [31:0] v);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_DIMS:    geo_dims = (v[1:0] == 2'd0) ? 1 : v[1:0];
      REG_CELLS_X: geo_x = clamp_cells(v);
      REG_CELLS_Y: geo_y = clamp_cells(v);
      REG_CELLS_Z: geo_z = clamp_cells(v);
      REG_INV_X:   inv_w[0] = v;
      REG_INV_Y:   inv_w[1] = v;
      REG_INV_Z:   inv_w[2] = v;
      default: ;
    endcase
    if (idx inside {REG_DIMS, REG_CELLS_X, REG_CELLS_Y, REG_CELLS_Z}) begin
      px = 0; py = 0; pz = 0;
    end
  endtask

  task automatic set_geometry(logic [31:0] nd, logic [31:0] nx, logic [31:0] ny,
                              logic [31:0] nz);
    // junk in the upper bits must be ignored
    cfg_write(REG_DIMS,    {$urandom} << 2 | nd[1:0]);
    cfg_write(REG_CELLS_X, {$urandom} << 7 | nx[6:0]);
    cfg_write(REG_CELLS_Y, {$urandom} << 7 | ny[6:0]);
    cfg_write(REG_CELLS_Z, {$urandom} << 7 | nz[6:0]);
  endtask

  task automatic set_widths(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
    cfg_write(REG_INV_X, ix);
    cfg_write(REG_INV_Y, iy);
    cfg_write(REG_INV_Z, iz);
  endtask

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_cell(cell_t c, bit fixed, grad_t want);
    grad_t g;
    while (idle_now()) begin
      cin.valid = 1'b0;
      @(negedge clk);
    end
    cin.valid       = 1'b1;
    cin.scalar_part = c[0];
    cin.vec_x       = c[1];
    cin.vec_y       = c[2];
    cin.vec_z       = c[3];
    cin.biv_x       = c[4];
    cin.biv_y       = c[5];
    cin.biv_z       = c[6];
    cin.pseudo_part = c[7];
    do @(posedge clk); while (!cin.ready);
    @(negedge clk);
    if (stencil_step(c, g)) grad_expect.push_back(fixed ? want : g);
  endtask

  task automatic drain();
    cin.valid = 1'b0;
    while (grad_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return QMIN;
      1:       return QMAX;
      2, 3:    return {$urandom};
      default: return $signed($urandom_range(262143)) - 131072;
    endcase
  endfunction

  function automatic logic [31:0] rand_inv();
    case ($urandom_range(5))
      0:       return ONE;
      1:       return 32'h0;
      2:       return {$urandom};
      default: return $urandom_range(2 * ONE);
    endcase
  endfunction

  task automatic stream_cells(int n);
    cell_t c;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 8; k++) c[k] = rand_word();
      send_cell(c, 1'b0, '0);
    end
  endtask

  function automatic int grid_len();
    return (geo_x + 2) * ((geo_dims >= 2) ? geo_y + 2 : geo_y)
           * ((geo_dims >= 3) ? geo_z + 2 : geo_z);
  endfunction

  // result side: random back-pressure
  always @(negedge clk) gout.ready <= !rst && !idle_now();

  always @(posedge clk) begin
    if (!rst && gout.valid && gout.ready) begin
      if (grad_expect.size() == 0) begin
        $error("unexpected gradient beat");
        errors++;
      end else begin
        grad_t w;
        cell_t got;
        w   = grad_expect.pop_front();
        got = {gout.grad_pseudo, gout.grad_biv_z, gout.grad_biv_y, gout.grad_biv_x,
               gout.grad_vec_z, gout.grad_vec_y, gout.grad_vec_x, gout.grad_scalar};
        for (int k = 0; k < 8; k++)
          if (got[k] !== w.g[k]) begin
            $error("%s: expected %h, got %h", comp_name[k], w.g[k], got[k]);
            errors++;
          end
        if (gout.last_cell !== w.last) begin
          $error("last_cell: expected %b, got %b", w.last, gout.last_cell);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT) begin
      $display("** multivector_gradient_stencil_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int done, n, phase;
    cin.valid = 1'b0;
    {cin.scalar_part, cin.vec_x, cin.vec_y, cin.vec_z} = '0;
    {cin.biv_x, cin.biv_y, cin.biv_z, cin.pseudo_part} = '0;
    gout.ready = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_DIMS;
    cfg_data   = '0;
    geo_dims = 3; geo_x = 64; geo_y = 64; geo_z = 64;
    inv_w = '{ONE, ONE, ONE};
    px = 0; py = 0; pz = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: widths left at their reset value
    set_geometry(1, 1, 1, 1);
    foreach (dir_rows[i]) send_cell(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].want);
    drain();

    // geometry extremes, out-of-range values clamped
    cfg_write(REG_SPARE, {$urandom});
    set_geometry(1, 64, 0, 0);
    set_widths(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    stream_cells(grid_len());
    drain();
    set_geometry(2, 1, 127, 1);
    set_widths(0, ONE, 0);
    stream_cells(grid_len());
    drain();
    set_geometry(3, 0, 1, 64);
    set_widths(ONE >> 1, 3 * ONE, ONE + 1);
    stream_cells(grid_len());
    drain();
    set_geometry(0, 2, 3, 1);
    set_widths(ONE, 32'h8000, 1);
    stream_cells(grid_len() + 5);
    drain();

    // random phases, mostly small grids
    done  = 0;
    phase = 0;
    while (done < RAND_ITEMS) begin
      calm = (phase == 3);
      if ($urandom_range(9) == 0)
        set_geometry($urandom_range(3), $urandom_range(127), $urandom_range(127),
                     $urandom_range(2));
      else
        set_geometry($urandom_range(3), $urandom_range(4), $urandom_range(4),
                     $urandom_range(4));
      set_widths(rand_inv(), rand_inv(), rand_inv());
      n = grid_len() * $urandom_range(1, 2) + $urandom_range(grid_len() - 1);
      if (n > 600) n = 600;
      // the stall-free stretch runs long enough to fill the pipeline many times
      if (calm && n < 300) n = 300;
      stream_cells(n);
      done += n;
      drain();
      phase++;
    end
    calm = 1'b0;

    if (errors == 0)
      $display("** multivector_gradient_stencil_unit: PASSED **");
    else
      $display("** multivector_gradient_stencil_unit: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mgs_pkg.sv
rtl/core/mgs_if.sv
rtl/core/mgs_front.sv
rtl/core/mgs_queue.sv
rtl/core/mgs_back.sv
rtl/core/multivector_gradient_stencil_unit.sv
test/multivector_gradient_stencil_unit_test.sv
